// ----- rtl/diagonal_word_hit_binner_assert.svh -----
// assertion helpers used by diagonal_word_hit_binner.sv
`ifndef DIAGONAL_WORD_HIT_BINNER_ASSERT_SVH
`define DIAGONAL_WORD_HIT_BINNER_ASSERT_SVH

// condition must hold on the same edge as its trigger
`define DWHB_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition must hold on the edge after its trigger
`define DWHB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/dwhb_pkg.sv -----
// ----------------------------------------------------------------------------
// dwhb_pkg
// types and constants shared by the diagonal word hit binner
// ----------------------------------------------------------------------------
package dwhb_pkg;

    localparam int MAX_DIAGONALS = 256;
    localparam int DIAG_W        = $clog2(MAX_DIAGONALS);
    localparam int CNT_W         = DIAG_W + 1;
    localparam int MAX_SEQ_LEN   = 65536;
    localparam int LEN_W         = 17;
    localparam int POS_W         = 16;
    localparam int TOTAL_W       = 24;
    localparam int OFFS_W        = 17;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(MAX_SEQ_LEN);

    typedef enum logic [0:0] {
        CFG_TARGET_LENGTH = 1'b0,
        CFG_QUERY_LENGTH  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             hit_valid;
        logic [POS_W-1:0] target_pos;
        logic [POS_W-1:0] query_pos;
        logic [LEN_W-1:0] hit_length;
        logic             last_hit;
    } t_in_beat;

    typedef struct packed {
        logic [TOTAL_W-1:0] best_score;
        logic [POS_W-1:0]   target_start;
        logic [POS_W-1:0]   query_start;
        logic [POS_W-1:0]   target_end;
        logic [POS_W-1:0]   query_end;
        logic               table_overflow;
    } t_out_beat;

    // hit broadcast to every cell
    typedef struct packed {
        logic                     update;
        logic signed [OFFS_W-1:0] diag;
        logic [LEN_W-1:0]         len;
    } t_hit_bus;

    // running maximum passed along the chain
    typedef struct packed {
        logic                     found;
        logic [TOTAL_W-1:0]       total;
        logic signed [OFFS_W-1:0] diag;
    } t_scan;

endpackage

// ----- rtl/dwhb_cell.sv -----
// ----------------------------------------------------------------------------
// dwhb_cell
// one diagonal entry: match, accumulate, and one stage of the max scan
// ----------------------------------------------------------------------------
module dwhb_cell (
    input  logic              i_clk,
    input  logic              i_live,
    input  logic              i_alloc,
    input  dwhb_pkg::t_hit_bus i_hit,
    input  dwhb_pkg::t_scan    i_scan,
    output logic              o_match,
    output dwhb_pkg::t_scan    o_scan
);
    import dwhb_pkg::*;

    logic signed [OFFS_W-1:0] r_offset;
    logic [TOTAL_W-1:0]       r_total;
    logic [TOTAL_W:0]         w_sum;
    t_scan                    r_scan;
    t_scan                    n_scan;

    assign o_match = i_live && (r_offset == i_hit.diag);
    assign w_sum   = {1'b0, r_total} + (TOTAL_W+1)'(i_hit.len);

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_offset <= i_hit.diag;
            r_total  <= TOTAL_W'(i_hit.len);
        end else if (i_hit.update && o_match) begin
            r_total <= w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
        end
    end

    // strict compare keeps the earlier entry on a tie
    always_comb begin
        n_scan = i_scan;
        if (i_live && (!i_scan.found || r_total > i_scan.total)) begin
            n_scan.found = 1'b1;
            n_scan.total = r_total;
            n_scan.diag  = r_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

// ----- rtl/dwhb_band.sv -----
// ----------------------------------------------------------------------------
// dwhb_band
// ungapped band from the winning diagonal and the sequence lengths
// ----------------------------------------------------------------------------
module dwhb_band (
    input  dwhb_pkg::t_scan        i_best,
    input  logic [16:0]            i_target_length,
    input  logic [16:0]            i_query_length,
    input  logic                   i_overflow,
    output dwhb_pkg::t_out_beat    o_beat
);
    import dwhb_pkg::*;

    localparam int W = LEN_W + 2;

    logic [LEN_W-1:0]    w_tlen;
    logic [LEN_W-1:0]    w_qlen;
    logic                w_pos;
    logic [OFFS_W-1:0]   w_ts;
    logic [OFFS_W-1:0]   w_qs;
    logic signed [W-1:0] w_a;
    logic signed [W-1:0] w_b;
    logic signed [W-1:0] w_min;
    logic signed [W-1:0] w_steps;
    logic signed [W-1:0] w_te;
    logic signed [W-1:0] w_qe;

    function automatic logic [POS_W-1:0] sat16(input logic signed [W-1:0] v);
        logic [POS_W-1:0] res;
        if (v < 0) res = '0;
        else if (v > W'(signed'({1'b0, {POS_W{1'b1}}}))) res = {POS_W{1'b1}};
        else res = v[POS_W-1:0];
        return res;
    endfunction

    always_comb begin
        w_tlen = (i_target_length > LEN_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN)
                                                         : i_target_length;
        w_qlen = (i_query_length > LEN_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN)
                                                        : i_query_length;
        w_pos  = !i_best.diag[OFFS_W-1] && (i_best.diag != '0);
        w_ts   = w_pos ? i_best.diag : '0;
        w_qs   = w_pos ? '0 : OFFS_W'(-i_best.diag);
        w_a    = signed'(W'(w_tlen)) - W'(1) - signed'(W'(w_ts));
        w_b    = signed'(W'(w_qlen)) - W'(1) - signed'(W'(w_qs));
        w_min  = (w_a < w_b) ? w_a : w_b;
        w_steps = (w_min < 0) ? '0 : w_min;
        w_te   = signed'(W'(w_ts)) + w_steps;
        w_qe   = signed'(W'(w_qs)) + w_steps;

        o_beat = '0;
        o_beat.table_overflow = i_overflow;
        if (i_best.found) begin
            o_beat.best_score   = i_best.total;
            o_beat.target_start = sat16(signed'(W'(w_ts)));
            o_beat.query_start  = sat16(signed'(W'(w_qs)));
            o_beat.target_end   = sat16(w_te);
            o_beat.query_end    = sat16(w_qe);
        end
    end

endmodule

// ----- rtl/diagonal_word_hit_binner.sv -----
// a hit beat is captured in ST_IDLE and folded into the table in ST_UPDATE the cycle after; the
//   input stalls outside ST_IDLE. a last-hit beat then goes to ST_SCAN, then ST_EMIT loads the
//   result register once the output is free
// ST_SCAN lasts until r_cnt has covered the chain, the running maximum stepping one cell per cycle
// reset: sync active low; table empty, overflow flag clear, both lengths 65536, no result pending
// ----------------------------------------------------------------------------
// diagonal_word_hit_binner
// bins word hits by diagonal in a chain of cells and reports the best band
// ----------------------------------------------------------------------------
module diagonal_word_hit_binner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dwhb_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dwhb_pkg::t_out_beat   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  dwhb_pkg::t_cfg_index  i_cfg_index,
    input  logic [16:0]           i_cfg_data
);
    import dwhb_pkg::*;

`include "diagonal_word_hit_binner_assert.svh"

    // control state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_used;
    logic             r_overflow;
    logic [DIAG_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_tlen;
    logic [LEN_W-1:0] r_qlen;

    // held hit, no reset needed
    logic                     r_hit_valid;
    logic                     r_last;
    logic signed [OFFS_W-1:0] r_diag;
    logic [LEN_W-1:0]         r_len;
    t_out_beat                r_out;

    // decoded controls
    logic      w_accept;
    logic      w_update;
    logic      w_load_out;
    logic      w_out_free;
    logic      w_full;
    logic      w_match_any;
    logic      w_alloc;
    t_hit_bus  w_hit;
    t_out_beat w_band;

    logic [MAX_DIAGONALS-1:0] w_match;
    logic [MAX_DIAGONALS-1:0] w_live;
    logic [MAX_DIAGONALS-1:0] w_cell_alloc;
    t_scan                    w_scan [MAX_DIAGONALS+1];

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_full      = r_used[DIAG_W];
    assign w_match_any = |w_match;
    assign w_alloc     = w_update && r_hit_valid && !w_match_any && !w_full;

    assign w_hit.update = w_update && r_hit_valid;
    assign w_hit.diag   = r_diag;
    assign w_hit.len    = r_len;

    // ---------------------------------------------------------------------
    // fsm: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_last ? ST_SCAN : ST_IDLE;
            ST_SCAN:   if (r_cnt == DIAG_W'(MAX_DIAGONALS - 1)) n_state = ST_EMIT;
            ST_EMIT:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // fsm: outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        w_update   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_UPDATE: w_update   = 1'b1;
            ST_SCAN:   ;
            ST_EMIT:   w_load_out = w_out_free;
            default:   ;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_overflow  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_tlen      <= LEN_RESET;
            r_qlen      <= LEN_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET_LENGTH: r_tlen <= i_cfg_data;
                    CFG_QUERY_LENGTH:  r_qlen <= i_cfg_data;
                    default:           ;
                endcase
            end

            // new diagonal goes into the next free cell, or is dropped when full
            if (w_alloc) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (w_update && r_hit_valid && !w_match_any && w_full) begin
                r_overflow <= 1'b1;
            end

            // scan counter runs while the maximum walks down the chain
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + DIAG_W'(1);
            end else begin
                r_cnt <= '0;
            end

            // result register parts the output side from the table
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_used      <= '0;
                r_overflow  <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hit capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit_valid <= i_in_data.hit_valid;
            r_last      <= i_in_data.last_hit;
            r_diag      <= signed'(OFFS_W'(i_in_data.target_pos))
                         - signed'(OFFS_W'(i_in_data.query_pos));
            r_len       <= i_in_data.hit_length;
        end
        if (w_load_out) begin
            r_out <= w_band;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // cell chain: live cells are those below the fill count
    // ---------------------------------------------------------------------
    assign w_scan[0] = '0;

    for (genvar g = 0; g < MAX_DIAGONALS; g++) begin : g_cell
        assign w_live[g]       = CNT_W'(g) < r_used;
        assign w_cell_alloc[g] = w_alloc && (r_used[DIAG_W-1:0] == DIAG_W'(g));

        dwhb_cell u_cell (
            .i_clk   (i_clk),
            .i_live  (w_live[g]),
            .i_alloc (w_cell_alloc[g]),
            .i_hit   (w_hit),
            .i_scan  (w_scan[g]),
            .o_match (w_match[g]),
            .o_scan  (w_scan[g+1])
        );
    end

    // band from the chain end, settled once the scan is done
    dwhb_band u_band (
        .i_best          (w_scan[MAX_DIAGONALS]),
        .i_target_length (r_tlen),
        .i_query_length  (r_qlen),
        .i_overflow      (r_overflow),
        .o_beat          (w_band)
    );

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    `DWHB_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CNT_W'(MAX_DIAGONALS), "fill count past table size")
    `DWHB_ASSERT_NOW(a_single_match, w_update, $onehot0(w_match), "diagonal held by two cells")
    `DWHB_ASSERT_NEXT(a_emit_clears, w_load_out, r_out_valid && (r_used == '0) && !r_overflow, "result load did not clear table")

endmodule
